// ===== sv/tafb_pkg.sv =====
// package for the thumb alu, flags and branch unit
// holds command and branch kind codes and the architectural state type; no dependencies
`timescale 1ns / 1ps

package tafb_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OffW  = 11;

  typedef enum logic [5:0] {
    CMD_ADC    = 6'd0,
    CMD_ADD    = 6'd1,
    CMD_EOR    = 6'd2,
    CMD_ORR    = 6'd3,
    CMD_AND    = 6'd4,
    CMD_MOV    = 6'd5,
    CMD_SUB    = 6'd6,
    CMD_CMP    = 6'd7,
    CMD_CMN    = 6'd8,
    CMD_MUL    = 6'd9,
    CMD_TST    = 6'd10,
    CMD_LSL    = 6'd11,
    CMD_LSR    = 6'd12,
    CMD_ROR    = 6'd13,
    CMD_ASR    = 6'd14,
    CMD_REV    = 6'd15,
    CMD_BIC    = 6'd16,
    CMD_MVN    = 6'd17,
    CMD_NOP    = 6'd18,
    CMD_RSB    = 6'd19,
    CMD_SBC    = 6'd20,
    CMD_BEQ    = 6'd21,
    CMD_BNE    = 6'd22,
    CMD_BCS    = 6'd23,
    CMD_BCC    = 6'd24,
    CMD_BMI    = 6'd25,
    CMD_BPL    = 6'd26,
    CMD_BVS    = 6'd27,
    CMD_BVC    = 6'd28,
    CMD_BHI    = 6'd29,
    CMD_BLS    = 6'd30,
    CMD_BGE    = 6'd31,
    CMD_BLT    = 6'd32,
    CMD_BGT    = 6'd33,
    CMD_BLE    = 6'd34,
    CMD_BRANCH = 6'd35
  } cmd_e;

  typedef enum logic [1:0] {
    BK_PLAIN = 2'd0,
    BK_LINK  = 2'd1,
    BK_REG   = 2'd2
  } branch_kind_e;

  typedef struct packed {
    logic             n;
    logic             z;
    logic             c;
    logic             v;
    logic [DataW-1:0] pc;
    logic [DataW-1:0] lr;
  } arch_state_t;

endpackage

// ===== sv/tafb_exec.sv =====
// combinational execute logic: alu, shifter, flag update and next pc / lr
// depends on tafb_pkg
`timescale 1ns / 1ps

module tafb_exec (
  input  logic [5:0]                        command_i,
  input  logic [1:0]                        branch_kind_i,
  input  logic [tafb_pkg::DataW-1:0]        operand_a_i,
  input  logic [tafb_pkg::DataW-1:0]        operand_b_i,
  input  logic signed [tafb_pkg::OffW-1:0]  branch_offset_i,
  input  tafb_pkg::arch_state_t             state_i,
  output logic [tafb_pkg::DataW-1:0]        result_o,
  output logic                              writes_register_o,
  output tafb_pkg::arch_state_t             state_o
);
  import tafb_pkg::*;

  cmd_e             cmd;
  logic [4:0]       sh;
  logic [4:0]       lsl_idx;
  logic [4:0]       rsh_idx;
  logic [DataW-1:0] add_x;
  logic [DataW-1:0] add_y;
  logic             add_cin;
  logic [DataW:0]   add_sum;
  logic [DataW-1:0] add_r;
  logic             add_v;
  logic [DataW-1:0] mul_r;
  logic [DataW-1:0] ror_r;
  logic [2*DataW-1:0] ror_wide;
  logic [DataW-1:0] step;
  logic             cond_ok;
  logic [DataW-1:0] r;
  logic             wr;
  logic             set_nz;

  assign cmd     = cmd_e'(command_i);
  assign sh      = operand_b_i[4:0];
  assign lsl_idx = 5'(6'd32 - {1'b0, sh});
  assign rsh_idx = sh - 5'd1;
  assign step    = {{(DataW-OffW-1){branch_offset_i[OffW-1]}}, branch_offset_i, 1'b0};
  assign mul_r   = operand_a_i * operand_b_i;
  assign ror_wide = {operand_a_i, operand_a_i} >> sh;
  assign ror_r   = ror_wide[DataW-1:0];

  // shared adder operand selection
  always_comb begin
    add_x   = operand_a_i;
    add_y   = operand_b_i;
    add_cin = 1'b0;
    case (cmd) inside
      CMD_ADC: begin
        add_cin = state_i.c;
      end
      CMD_SUB, CMD_CMP: begin
        add_y   = ~operand_b_i;
        add_cin = 1'b1;
      end
      CMD_SBC: begin
        add_y   = ~operand_b_i;
        add_cin = state_i.c;
      end
      CMD_RSB: begin
        add_x   = '0;
        add_y   = ~operand_a_i;
        add_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_r   = add_sum[DataW-1:0];
  assign add_v   = ~(add_x[DataW-1] ^ add_y[DataW-1]) & (add_x[DataW-1] ^ add_r[DataW-1]);

  always_comb begin
    unique case (command_i[3:0] - 4'd5)
      4'd0:    cond_ok = state_i.z;
      4'd1:    cond_ok = ~state_i.z;
      4'd2:    cond_ok = state_i.c;
      4'd3:    cond_ok = ~state_i.c;
      4'd4:    cond_ok = state_i.n;
      4'd5:    cond_ok = ~state_i.n;
      4'd6:    cond_ok = state_i.v;
      4'd7:    cond_ok = ~state_i.v;
      4'd8:    cond_ok = state_i.c & ~state_i.z;
      4'd9:    cond_ok = ~state_i.c | state_i.z;
      4'd10:   cond_ok = state_i.n == state_i.v;
      4'd11:   cond_ok = state_i.n != state_i.v;
      4'd12:   cond_ok = ~state_i.z & (state_i.n == state_i.v);
      default: cond_ok = state_i.z | (state_i.n != state_i.v);
    endcase
  end

  always_comb begin
    state_o = state_i;
    r       = '0;
    wr      = 1'b0;
    set_nz  = 1'b0;
    unique case (cmd) inside
      CMD_ADC, CMD_ADD, CMD_SUB, CMD_RSB, CMD_SBC: begin
        r  = add_r;
        wr = 1'b1;
        set_nz    = 1'b1;
        state_o.c = add_sum[DataW];
        state_o.v = add_v;
      end
      CMD_CMP, CMD_CMN: begin
        r  = add_r;
        set_nz    = 1'b1;
        state_o.c = add_sum[DataW];
        state_o.v = add_v;
      end
      CMD_EOR: begin
        r = operand_a_i ^ operand_b_i; wr = 1'b1; set_nz = 1'b1;
      end
      CMD_ORR: begin
        r = operand_a_i | operand_b_i; wr = 1'b1; set_nz = 1'b1;
      end
      CMD_AND: begin
        r = operand_a_i & operand_b_i; wr = 1'b1; set_nz = 1'b1;
      end
      CMD_TST: begin
        r = operand_a_i & operand_b_i; set_nz = 1'b1;
      end
      CMD_MOV: begin
        r = operand_a_i; wr = 1'b1; set_nz = 1'b1;
      end
      CMD_MUL: begin
        r = mul_r; wr = 1'b1; set_nz = 1'b1;
      end
      CMD_BIC: begin
        r = operand_a_i & ~operand_b_i; wr = 1'b1; set_nz = 1'b1;
      end
      CMD_MVN: begin
        r = ~operand_a_i; wr = 1'b1; set_nz = 1'b1;
      end
      CMD_LSL: begin
        r = operand_a_i << sh; wr = 1'b1; set_nz = 1'b1;
        if (sh != 5'd0) state_o.c = operand_a_i[lsl_idx];
      end
      CMD_LSR: begin
        r = operand_a_i >> sh; wr = 1'b1; set_nz = 1'b1;
        if (sh != 5'd0) state_o.c = operand_a_i[rsh_idx];
      end
      CMD_ASR: begin
        r = DataW'($signed(operand_a_i) >>> sh); wr = 1'b1; set_nz = 1'b1;
        if (sh != 5'd0) state_o.c = operand_a_i[rsh_idx];
      end
      CMD_ROR: begin
        r = ror_r; wr = 1'b1; set_nz = 1'b1;
        if (sh != 5'd0) state_o.c = ror_r[DataW-1];
      end
      CMD_REV: begin
        r  = {operand_a_i[7:0], operand_a_i[15:8], operand_a_i[23:16], operand_a_i[31:24]};
        wr = 1'b1;
      end
      default: begin
      end
    endcase
    if (set_nz) begin
      state_o.n = r[DataW-1];
      state_o.z = (r == '0);
    end

    // program counter and link register
    unique case (cmd) inside
      [CMD_BEQ:CMD_BLE]: begin
        state_o.pc = state_i.pc + (cond_ok ? step : DataW'(2));
      end
      CMD_BRANCH: begin
        unique case (branch_kind_e'(branch_kind_i))
          BK_LINK: begin
            state_o.lr = state_i.pc + DataW'(2);
            state_o.pc = state_i.pc + step;
          end
          BK_REG:  state_o.pc = operand_a_i;
          default: state_o.pc = state_i.pc + step;
        endcase
      end
      default: begin
        state_o.pc = state_i.pc + DataW'(2);
      end
    endcase
  end

  assign result_o          = wr ? r : '0;
  assign writes_register_o = wr;

endmodule

// ===== sv/thumb_alu_flags_branch_unit.sv =====
// pipeline: two register stages (input register, then result register); an accepted word moves
// on once the result register is empty or not stalled; throughput one word per cycle, input
// stalls only while the input register is full and the result word is held by output stall
// flags, pc and link register update as each word passes the execute stage
// reset clears flags, pc, link register and both valid bits; depends on tafb_pkg, tafb_exec
`timescale 1ns / 1ps

module thumb_alu_flags_branch_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [5:0]                        command_i,
  input  logic [1:0]                        branch_kind_i,
  input  logic [tafb_pkg::DataW-1:0]        operand_a_i,
  input  logic [tafb_pkg::DataW-1:0]        operand_b_i,
  input  logic signed [tafb_pkg::OffW-1:0]  branch_offset_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tafb_pkg::DataW-1:0]        result_value_o,
  output logic                              writes_register_o,
  output logic                              flag_negative_o,
  output logic                              flag_zero_o,
  output logic                              flag_carry_o,
  output logic                              flag_overflow_o,
  output logic [tafb_pkg::DataW-1:0]        program_counter_o,
  output logic [tafb_pkg::DataW-1:0]        link_value_o
);
  import tafb_pkg::*;

  logic                    in_vld_q;
  logic [5:0]              cmd_q;
  logic [1:0]              kind_q;
  logic [DataW-1:0]        a_q;
  logic [DataW-1:0]        b_q;
  logic signed [OffW-1:0]  off_q;

  arch_state_t             state_q;
  arch_state_t             state_d;
  logic [DataW-1:0]        res_d;
  logic                    wr_d;

  logic                    out_vld_q;
  logic [DataW-1:0]        res_q;
  logic                    wr_q;
  arch_state_t             out_state_q;

  logic                    advance;
  logic                    in_take;

  assign advance    = ~out_vld_q | ~out_stall_i;
  assign in_stall_o = in_vld_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  tafb_exec u_exec (
    .command_i         (cmd_q),
    .branch_kind_i     (kind_q),
    .operand_a_i       (a_q),
    .operand_b_i       (b_q),
    .branch_offset_i   (off_q),
    .state_i           (state_q),
    .result_o          (res_d),
    .writes_register_o (wr_d),
    .state_o           (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= command_i;
      kind_q <= branch_kind_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      off_q  <= branch_offset_i;
    end
    if (advance && in_vld_q) begin
      res_q       <= res_d;
      wr_q        <= wr_d;
      out_state_q <= state_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign result_value_o    = res_q;
  assign writes_register_o = wr_q;
  assign flag_negative_o   = out_state_q.n;
  assign flag_zero_o       = out_state_q.z;
  assign flag_carry_o      = out_state_q.c;
  assign flag_overflow_o   = out_state_q.v;
  assign program_counter_o = out_state_q.pc;
  assign link_value_o      = out_state_q.lr;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for thumb_alu_flags_branch_unit: a directed table, then random words
// checked against an in-bench execute model of flags, pc and link register; imports tafb_pkg only
`timescale 1ns / 1ps

module tb_top;
  import tafb_pkg::*;

  localparam logic [5:0] CmdUnused  = 6'd63;
  localparam logic [1:0] BkSpare    = 2'd3;
  localparam int         PhaseWords = 185;
  localparam int         HoldCycles = 60;
  localparam int         TailCycles = 8;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [1:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [10:0] off;
  } word_t;

  typedef struct packed {
    logic [31:0] r;
    logic        wr;
    logic        n;
    logic        z;
    logic        c;
    logic        v;
    logic [31:0] pc;
    logic [31:0] lr;
  } exec_res_t;

  typedef struct packed {
    word_t     w;
    logic      typed;
    exec_res_t res;
  } stim_row_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [5:0]  command_i         = '0;
  logic [1:0]  branch_kind_i     = '0;
  logic [31:0] operand_a_i       = '0;
  logic [31:0] operand_b_i       = '0;
  logic signed [10:0] branch_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [31:0] result_value_o;
  logic        writes_register_o;
  logic        flag_negative_o;
  logic        flag_zero_o;
  logic        flag_carry_o;
  logic        flag_overflow_o;
  logic [31:0] program_counter_o;
  logic [31:0] link_value_o;

  arch_state_t model_st = '0;
  exec_res_t   pending_res_q[$];
  int          mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_starts   = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;

  stim_row_t directed_tbl [32] = '{
    '{'{CMD_NOP, BK_PLAIN, 32'h0, 32'h0, 11'd0}, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd2, 32'h0}},
    '{'{CMD_ADD, BK_PLAIN, 32'hFFFF_FFFF, 32'h1, 11'd0}, 1'b1,
      '{32'h0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 32'd4, 32'h0}},
    '{'{CMD_ADD, BK_PLAIN, 32'h7FFF_FFFF, 32'h1, 11'd0}, 1'b1,
      '{32'h8000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 32'd6, 32'h0}},
    '{'{CMD_SUB, BK_PLAIN, 32'h0, 32'h1, 11'd0}, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd8, 32'h0}},
    '{'{CMD_CMN, BK_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0}, 1'b0, '0},
    '{'{CMD_ADC, BK_PLAIN, 32'h1, 32'h2, 11'd0}, 1'b0, '0},
    '{'{CMD_SBC, BK_PLAIN, 32'h5, 32'h7, 11'd0}, 1'b0, '0},
    '{'{CMD_CMP, BK_PLAIN, 32'h8000_0000, 32'h1, 11'd0}, 1'b0, '0},
    '{'{CMD_RSB, BK_PLAIN, 32'h8000_0000, 32'h0, 11'd0}, 1'b0, '0},
    '{'{CMD_EOR, BK_PLAIN, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 11'd0}, 1'b0, '0},
    '{'{CMD_ORR, BK_PLAIN, 32'h0, 32'h8000_0000, 11'd0}, 1'b0, '0},
    '{'{CMD_AND, BK_PLAIN, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 11'd0}, 1'b0, '0},
    '{'{CMD_MOV, BK_PLAIN, 32'h0, 32'hFFFF_FFFF, 11'd0}, 1'b0, '0},
    '{'{CMD_MUL, BK_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0}, 1'b0, '0},
    '{'{CMD_TST, BK_PLAIN, 32'h8000_0000, 32'h7FFF_FFFF, 11'd0}, 1'b0, '0},
    '{'{CMD_LSL, BK_PLAIN, 32'h8000_0001, 32'h0, 11'd0}, 1'b0, '0},
    '{'{CMD_LSL, BK_PLAIN, 32'h8000_0001, 32'h1, 11'd0}, 1'b0, '0},
    '{'{CMD_LSR, BK_PLAIN, 32'h8000_0001, 32'h20, 11'd0}, 1'b0, '0},
    '{'{CMD_LSR, BK_PLAIN, 32'hFFFF_FFFF, 32'd31, 11'd0}, 1'b0, '0},
    '{'{CMD_ASR, BK_PLAIN, 32'h8000_0000, 32'd31, 11'd0}, 1'b0, '0},
    '{'{CMD_ROR, BK_PLAIN, 32'h0000_0001, 32'h1, 11'd0}, 1'b0, '0},
    '{'{CMD_REV, BK_PLAIN, 32'h1234_5678, 32'h0, 11'd0}, 1'b0, '0},
    '{'{CMD_BIC, BK_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_0000, 11'd0}, 1'b0, '0},
    '{'{CMD_MVN, BK_PLAIN, 32'hFFFF_FFFF, 32'h0, 11'd0}, 1'b0, '0},
    '{'{CMD_BEQ, BK_PLAIN, 32'h0, 32'h0, 11'd4}, 1'b0, '0},
    '{'{CMD_BPL, BK_PLAIN, 32'h0, 32'h0, 11'd1}, 1'b0, '0},
    '{'{CMD_BLE, BK_PLAIN, 32'h0, 32'h0, 11'h400}, 1'b0, '0},
    '{'{CMD_BRANCH, BK_PLAIN, 32'h0, 32'h0, 11'h3FF}, 1'b0, '0},
    '{'{CMD_BRANCH, BK_LINK, 32'h0, 32'h0, 11'h400}, 1'b0, '0},
    '{'{CMD_BRANCH, BK_REG, 32'hFFFF_FFFE, 32'h0, 11'h7FF}, 1'b0, '0},
    '{'{CMD_BRANCH, BkSpare, 32'h0, 32'h0, 11'd16}, 1'b0, '0},
    '{'{CmdUnused, BK_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF}, 1'b0, '0}
  };

  thumb_alu_flags_branch_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .branch_kind_i     (branch_kind_i),
    .operand_a_i       (operand_a_i),
    .operand_b_i       (operand_b_i),
    .branch_offset_i   (branch_offset_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_value_o    (result_value_o),
    .writes_register_o (writes_register_o),
    .flag_negative_o   (flag_negative_o),
    .flag_zero_o       (flag_zero_o),
    .flag_carry_o      (flag_carry_o),
    .flag_overflow_o   (flag_overflow_o),
    .program_counter_o (program_counter_o),
    .link_value_o      (link_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void set_nz(input logic [31:0] r);
    model_st.n = r[31];
    model_st.z = (r == 32'h0);
  endfunction

  function automatic logic [31:0] add_nzcv(input logic [31:0] x, input logic [31:0] y,
                                           input logic cin);
    logic [32:0] wide;
    wide = {1'b0, x} + {1'b0, y} + {32'h0, cin};
    model_st.c = wide[32];
    model_st.v = ~(x[31] ^ y[31]) & (x[31] ^ wide[31]);
    set_nz(wide[31:0]);
    return wide[31:0];
  endfunction

  function automatic exec_res_t execute_word(input word_t w);
    exec_res_t   res;
    logic [31:0] r;
    logic [31:0] step;
    logic [4:0]  sh;
    logic        wr;
    logic        taken;
    r     = '0;
    wr    = 1'b0;
    taken = 1'b0;
    sh    = w.b[4:0];
    step  = {{20{w.off[10]}}, w.off, 1'b0};
    case (w.cmd)
      CMD_ADC: begin r = add_nzcv(w.a, w.b, model_st.c); wr = 1'b1; end
      CMD_ADD: begin r = add_nzcv(w.a, w.b, 1'b0); wr = 1'b1; end
      CMD_EOR: begin r = w.a ^ w.b; set_nz(r); wr = 1'b1; end
      CMD_ORR: begin r = w.a | w.b; set_nz(r); wr = 1'b1; end
      CMD_AND: begin r = w.a & w.b; set_nz(r); wr = 1'b1; end
      CMD_MOV: begin r = w.a; set_nz(r); wr = 1'b1; end
      CMD_SUB: begin r = add_nzcv(w.a, ~w.b, 1'b1); wr = 1'b1; end
      CMD_CMP: void'(add_nzcv(w.a, ~w.b, 1'b1));
      CMD_CMN: void'(add_nzcv(w.a, w.b, 1'b0));
      CMD_MUL: begin r = w.a * w.b; set_nz(r); wr = 1'b1; end
      CMD_TST: set_nz(w.a & w.b);
      CMD_LSL: begin
        r = w.a;
        if (sh != 0) begin
          model_st.c = w.a[32 - sh];
          r = w.a << sh;
        end
        set_nz(r);
        wr = 1'b1;
      end
      CMD_LSR: begin
        r = w.a;
        if (sh != 0) begin
          model_st.c = w.a[sh - 1];
          r = w.a >> sh;
        end
        set_nz(r);
        wr = 1'b1;
      end
      CMD_ROR: begin
        r = w.a;
        if (sh != 0) begin
          r = (w.a >> sh) | (w.a << (32 - sh));
          model_st.c = r[31];
        end
        set_nz(r);
        wr = 1'b1;
      end
      CMD_ASR: begin
        r = w.a;
        if (sh != 0) begin
          model_st.c = w.a[sh - 1];
          r = $signed(w.a) >>> sh;
        end
        set_nz(r);
        wr = 1'b1;
      end
      CMD_REV: begin r = {w.a[7:0], w.a[15:8], w.a[23:16], w.a[31:24]}; wr = 1'b1; end
      CMD_BIC: begin r = w.a & ~w.b; set_nz(r); wr = 1'b1; end
      CMD_MVN: begin r = ~w.a; set_nz(r); wr = 1'b1; end
      CMD_RSB: begin r = add_nzcv(32'h0, ~w.a, 1'b1); wr = 1'b1; end
      CMD_SBC: begin r = add_nzcv(w.a, ~w.b, model_st.c); wr = 1'b1; end
      CMD_BEQ: taken = model_st.z;
      CMD_BNE: taken = !model_st.z;
      CMD_BCS: taken = model_st.c;
      CMD_BCC: taken = !model_st.c;
      CMD_BMI: taken = model_st.n;
      CMD_BPL: taken = !model_st.n;
      CMD_BVS: taken = model_st.v;
      CMD_BVC: taken = !model_st.v;
      CMD_BHI: taken = model_st.c && !model_st.z;
      CMD_BLS: taken = !model_st.c || model_st.z;
      CMD_BGE: taken = (model_st.n == model_st.v);
      CMD_BLT: taken = (model_st.n != model_st.v);
      CMD_BGT: taken = !model_st.z && (model_st.n == model_st.v);
      CMD_BLE: taken = model_st.z || (model_st.n != model_st.v);
      default: ;
    endcase
    if (w.cmd >= CMD_BEQ && w.cmd <= CMD_BLE) begin
      model_st.pc = model_st.pc + (taken ? step : 32'd2);
    end else if (w.cmd == CMD_BRANCH) begin
      case (w.kind)
        BK_LINK: begin
          model_st.lr = model_st.pc + 32'd2;
          model_st.pc = model_st.pc + step;
        end
        BK_REG:  model_st.pc = w.a;
        default: model_st.pc = model_st.pc + step;
      endcase
    end else begin
      model_st.pc = model_st.pc + 32'd2;
    end
    res = '{wr ? r : 32'h0, wr, model_st.n, model_st.z, model_st.c, model_st.v,
            model_st.pc, model_st.lr};
    return res;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t random_word();
    word_t       w;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 62) w.cmd = 6'($urandom_range(CMD_SBC));
    else if (sel < 90) w.cmd = 6'($urandom_range(CMD_BRANCH, CMD_BEQ));
    else w.cmd = 6'($urandom_range(CmdUnused, CMD_BRANCH + 1));
    w.kind = 2'($urandom_range(BkSpare));
    w.a    = pick_operand();
    w.b    = ($urandom_range(7) == 0) ? w.a : pick_operand();
    w.off  = 11'($urandom);
    return w;
  endfunction

  task automatic send_word(input word_t w, input logic typed, input exec_res_t typed_res);
    exec_res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= w.cmd;
    branch_kind_i   <= w.kind;
    operand_a_i     <= w.a;
    operand_b_i     <= w.b;
    branch_offset_i <= w.off;
    do @(posedge clk_i); while (in_stall_o);
    predicted = execute_word(w);
    pending_res_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_res_q.size() != 0);
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", fname, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    exec_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected");
      end else begin
        exp_r = pending_res_q.pop_front();
        check_field("result_value", exp_r.r, result_value_o);
        check_field("writes_register", 32'(exp_r.wr), 32'(writes_register_o));
        check_field("flag_negative", 32'(exp_r.n), 32'(flag_negative_o));
        check_field("flag_zero", 32'(exp_r.z), 32'(flag_zero_o));
        check_field("flag_carry", 32'(exp_r.c), 32'(flag_carry_o));
        check_field("flag_overflow", 32'(exp_r.v), 32'(flag_overflow_o));
        check_field("program_counter", exp_r.pc, program_counter_o);
        check_field("link_value", exp_r.lr, link_value_o);
      end
    end
  end

  // long hold-offs are counted here so the sender keeps offering words meanwhile
  always @(posedge clk_i) begin : result_stall
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_starts) begin
      hold_seen   <= hold_starts;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 31;
    recv_idle_pct = 57;
    foreach (directed_tbl[i])
      send_word(directed_tbl[i].w, directed_tbl[i].typed, directed_tbl[i].res);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 31; recv_idle_pct = 57; end
        1:       begin send_idle_pct = 57; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int i = 0; i < PhaseWords; i++) begin
        if (phase == 0 && i == 40) hold_starts = hold_starts + 1;
        send_word(random_word(), 1'b0, '0);
      end
      if (phase == 0) wait_drained();
    end
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== thumb_alu_flags_branch_unit.f =====
sv/tafb_pkg.sv
sv/tafb_exec.sv
sv/thumb_alu_flags_branch_unit.sv
test/tb_top.sv
